// ===== design/bcc_pkg.sv =====
// -----------------------------------------------------------------------------
// bcc_pkg
// Shared types and constants for the button click classifier.
// -----------------------------------------------------------------------------
`default_nettype none

package bcc_pkg;

   localparam int unsigned TimeWidth = 32;
   localparam int unsigned CfgWidth  = 16;
   localparam int unsigned CsrIndexWidth = 2;

   localparam logic [CfgWidth-1:0] MinPressReset    = 16'd30;
   localparam logic [CfgWidth-1:0] LongPressReset   = 16'd1500;
   localparam logic [CfgWidth-1:0] DoubleWindowReset = 16'd300;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_MIN_PRESS     = 2'd0,
      CSR_LONG_PRESS    = 2'd1,
      CSR_DOUBLE_WINDOW = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      PH_IDLE   = 2'd0,
      PH_FIRST  = 2'd1,
      PH_WAIT   = 2'd2,
      PH_SECOND = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      G_NONE   = 2'd0,
      G_SINGLE = 2'd1,
      G_DOUBLE = 2'd2,
      G_LONG   = 2'd3
   } gesture_type;

   // command field codes
   localparam logic CMD_EDGE  = 1'b0;
   localparam logic CMD_CHECK = 1'b1;

   // level field codes
   localparam logic LVL_PRESSED  = 1'b0;
   localparam logic LVL_RELEASED = 1'b1;

   typedef struct packed {
      logic [CfgWidth-1:0] min_press_ticks;
      logic [CfgWidth-1:0] long_press_ticks;
      logic [CfgWidth-1:0] double_window_ticks;
   } cfg_type;

   typedef struct packed {
      logic                 command;
      logic                 level;
      logic                 confirmed;
      logic [TimeWidth-1:0] time_stamp;
   } req_item_type;

   typedef struct packed {
      gesture_type          gesture;
      logic [TimeWidth-1:0] span_ticks;
   } rsp_item_type;

endpackage

`default_nettype wire

// ===== design/bcc_if.sv =====
// -----------------------------------------------------------------------------
// bcc_req_if / bcc_rsp_if
// Valid/ready channels for button events in and gesture results out.
// -----------------------------------------------------------------------------
`default_nettype none

interface bcc_req_if;
   logic                             valid;
   logic                             ready;
   logic                             command;
   logic                             level;
   logic                             confirmed;
   logic [bcc_pkg::TimeWidth-1:0]    time_stamp;

   modport source (output valid, output command, output level, output confirmed,
                   output time_stamp, input ready);
   modport sink   (input valid, input command, input level, input confirmed,
                   input time_stamp, output ready);
endinterface

interface bcc_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [1:0]                       gesture;
   logic [bcc_pkg::TimeWidth-1:0]    span_ticks;

   modport source (output valid, output gesture, output span_ticks, input ready);
   modport sink   (input valid, input gesture, input span_ticks, output ready);
endinterface

`default_nettype wire

// ===== design/bcc_csr.sv =====
// -----------------------------------------------------------------------------
// bcc_csr
// Threshold registers, written through a plain write port.
// -----------------------------------------------------------------------------
`default_nettype none

module bcc_csr (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_write_enable,
   input  wire logic [bcc_pkg::CsrIndexWidth-1:0]   csr_index,
   input  wire logic [bcc_pkg::CfgWidth-1:0]        csr_write_data,
   output bcc_pkg::cfg_type                         cfg
);

   bcc_pkg::cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_press_ticks     <= bcc_pkg::MinPressReset;
         cfg_ff.long_press_ticks    <= bcc_pkg::LongPressReset;
         cfg_ff.double_window_ticks <= bcc_pkg::DoubleWindowReset;
      end else if (csr_write_enable) begin
         case (bcc_pkg::csr_index_type'(csr_index))
            bcc_pkg::CSR_MIN_PRESS:     cfg_ff.min_press_ticks     <= csr_write_data;
            bcc_pkg::CSR_LONG_PRESS:    cfg_ff.long_press_ticks    <= csr_write_data;
            bcc_pkg::CSR_DOUBLE_WINDOW: cfg_ff.double_window_ticks <= csr_write_data;
            default: ;  // unmapped index, dropped
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ===== design/bcc_classify.sv =====
// -----------------------------------------------------------------------------
// bcc_classify
// Gesture state machine: phase and timestamps, one item per enable.
// -----------------------------------------------------------------------------
`default_nettype none

module bcc_classify (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                advance,
   input  wire bcc_pkg::req_item_type item,
   input  wire bcc_pkg::cfg_type    cfg,
   output bcc_pkg::rsp_item_type    result
);

   localparam int unsigned TW = bcc_pkg::TimeWidth;
   localparam int unsigned PadW = bcc_pkg::TimeWidth - bcc_pkg::CfgWidth;

   bcc_pkg::phase_type phase_ff, phase_in, eff_phase;
   logic [TW-1:0] first_press_ff, first_press_in;
   logic [TW-1:0] first_release_ff, first_release_in;
   logic [TW-1:0] second_press_ff, second_press_in;

   logic [TW-1:0] win_span, first_span, second_span, first_dur, gap_span;
   logic [TW-1:0] min_ext, long_ext, win_ext;
   logic          expired, edge_ok;
   logic          first_glitch, first_long, second_glitch, second_long;

   assign min_ext  = {{PadW{1'b0}}, cfg.min_press_ticks};
   assign long_ext = {{PadW{1'b0}}, cfg.long_press_ticks};
   assign win_ext  = {{PadW{1'b0}}, cfg.double_window_ticks};

   // wrapping tick differences
   assign win_span    = item.time_stamp - first_release_ff;
   assign first_span  = item.time_stamp - first_press_ff;
   assign second_span = item.time_stamp - second_press_ff;
   assign first_dur   = first_release_ff - first_press_ff;
   assign gap_span    = second_press_ff - first_release_ff;

   assign expired   = (phase_ff == bcc_pkg::PH_WAIT) && (win_span >= win_ext);
   assign eff_phase = expired ? bcc_pkg::PH_IDLE : phase_ff;
   assign edge_ok   = (item.command == bcc_pkg::CMD_EDGE) && item.confirmed;

   assign first_glitch  = first_span < min_ext;
   assign first_long    = first_span >= long_ext;
   assign second_glitch = second_span < min_ext;
   assign second_long   = second_span >= long_ext;

   // next state
   always_comb begin
      phase_in         = eff_phase;
      first_press_in   = first_press_ff;
      first_release_in = first_release_ff;
      second_press_in  = second_press_ff;
      if (edge_ok) begin
         case (eff_phase)
            bcc_pkg::PH_IDLE: begin
               if (item.level == bcc_pkg::LVL_PRESSED) begin
                  first_press_in = item.time_stamp;
                  phase_in       = bcc_pkg::PH_FIRST;
               end
            end
            bcc_pkg::PH_FIRST: begin
               if (item.level == bcc_pkg::LVL_RELEASED) begin
                  if (first_glitch || first_long) begin
                     phase_in = bcc_pkg::PH_IDLE;
                  end else begin
                     first_release_in = item.time_stamp;
                     phase_in         = bcc_pkg::PH_WAIT;
                  end
               end
            end
            bcc_pkg::PH_WAIT: begin
               if (item.level == bcc_pkg::LVL_PRESSED) begin
                  second_press_in = item.time_stamp;
                  phase_in        = bcc_pkg::PH_SECOND;
               end
            end
            bcc_pkg::PH_SECOND: begin
               if (item.level == bcc_pkg::LVL_RELEASED) begin
                  phase_in = bcc_pkg::PH_IDLE;
               end
            end
            default: phase_in = bcc_pkg::PH_IDLE;
         endcase
      end
   end

   // outputs
   always_comb begin
      result.gesture    = expired ? bcc_pkg::G_SINGLE : bcc_pkg::G_NONE;
      result.span_ticks = expired ? first_dur : '0;
      if (edge_ok && (item.level == bcc_pkg::LVL_RELEASED)) begin
         case (eff_phase)
            bcc_pkg::PH_FIRST: begin
               if (!first_glitch && first_long) begin
                  result.gesture    = bcc_pkg::G_LONG;
                  result.span_ticks = first_span;
               end
            end
            bcc_pkg::PH_SECOND: begin
               if (second_glitch) begin
                  result.gesture    = bcc_pkg::G_SINGLE;
                  result.span_ticks = first_dur;
               end else if (second_long) begin
                  result.gesture    = bcc_pkg::G_LONG;
                  result.span_ticks = second_span;
               end else begin
                  result.gesture    = bcc_pkg::G_DOUBLE;
                  result.span_ticks = gap_span;
               end
            end
            default: ;  // idle/wait: release ignored
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= bcc_pkg::PH_IDLE;
         first_press_ff   <= '0;
         first_release_ff <= '0;
         second_press_ff  <= '0;
      end else if (advance) begin
         phase_ff         <= phase_in;
         first_press_ff   <= first_press_in;
         first_release_ff <= first_release_in;
         second_press_ff  <= second_press_in;
      end
   end

endmodule

`default_nettype wire

// ===== design/button_click_classifier.sv =====
// -----------------------------------------------------------------------------
// button_click_classifier
// Sorts timestamped button edges and time checks into click gestures.
// -----------------------------------------------------------------------------
// Usage:
//  - req_chan carries one item per transfer: command (edge or time check),
//    level, confirmed and time_stamp. Every item yields exactly one result.
//  - rsp_chan carries gesture (none/single/double/long) and span_ticks.
//  - csr_* writes the three 16-bit thresholds (min press, long press,
//    double-click window); only write while the block is idle.
//  - Path: the req item is registered in the input register, then passes the
//    classify logic into the result register, which drives rsp valid.
//  - Throughput: one item per cycle while the result register is not stalled;
//    the phase/timestamp state updates in the same cycle the item leaves the
//    input register, so items follow back to back.
//  - Reset clears phase to idle, all timestamps to zero, thresholds to
//    30/1500/300 and empties both pipeline registers.
//  - If rsp ready drops, the result register holds, the input register
//    still takes one more item, then req ready drops until the sink drains.
// -----------------------------------------------------------------------------
`default_nettype none

module button_click_classifier (
   input  wire logic                                clock,
   input  wire logic                                reset,
   bcc_req_if.sink                                  req_chan,
   bcc_rsp_if.source                                rsp_chan,
   input  wire logic                                csr_write_enable,
   input  wire logic [bcc_pkg::CsrIndexWidth-1:0]   csr_index,
   input  wire logic [bcc_pkg::CfgWidth-1:0]        csr_write_data
);

   bcc_pkg::cfg_type      cfg;
   bcc_pkg::req_item_type req_item, s1_item_ff;
   bcc_pkg::rsp_item_type calc_result, out_item_ff;
   logic                  s1_vld_ff, out_vld_ff;
   logic                  advance, req_xfer;

   bcc_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   // item moves from input register to result register (and state updates)
   assign advance  = s1_vld_ff && (!out_vld_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_vld_ff || advance;
   assign req_xfer = req_chan.valid && req_chan.ready;

   assign req_item.command    = req_chan.command;
   assign req_item.level      = req_chan.level;
   assign req_item.confirmed  = req_chan.confirmed;
   assign req_item.time_stamp = req_chan.time_stamp;

   bcc_classify u_classify (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (s1_item_ff),
      .cfg     (cfg),
      .result  (calc_result)
   );

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (req_chan.ready) begin
         s1_vld_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_item_ff <= req_item;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (advance) begin
         out_vld_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         out_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_item_ff <= calc_result;
      end
   end

   assign rsp_chan.valid      = out_vld_ff;
   assign rsp_chan.gesture    = out_item_ff.gesture;
   assign rsp_chan.span_ticks = out_item_ff.span_ticks;

endmodule

`default_nettype wire

// ===== design/bcc_checker.sv =====
// -----------------------------------------------------------------------------
// bcc_checker
// Port-level checks on the classifier, bound to the top level.
// -----------------------------------------------------------------------------
`default_nettype none

module bcc_checker (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             rsp_valid,
   input  wire logic                             rsp_ready,
   input  wire logic [1:0]                       rsp_gesture,
   input  wire logic [bcc_pkg::TimeWidth-1:0]    rsp_span_ticks
);

   // stalled result stays offered
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp valid dropped while stalled");

   // no-gesture results always carry a zero span
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_gesture == bcc_pkg::G_NONE) |-> (rsp_span_ticks == '0))
      else $error("none gesture with nonzero span");

   // reset empties the result register
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid right after reset");

   // stalled payload holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_gesture) && $stable(rsp_span_ticks))
      else $error("rsp payload changed while stalled");

endmodule

bind button_click_classifier bcc_checker u_bcc_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_gesture    (rsp_chan.gesture),
   .rsp_span_ticks (rsp_chan.span_ticks)
);

`default_nettype wire

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tb
// Self-checking bench for the button click classifier. A table of hand-built
// events covers reset values, threshold edges, wrap-around and the odd level
// sequences. Random gesture sequences follow, with noise mixed in, under
// several threshold settings. Results are scored by the model or typed rows.
// -----------------------------------------------------------------------------

module tb;
   import bcc_pkg::*;

   localparam int LONG_HOLD = 40;      // receiver hold-off, in cycles

   // ---------------------------------------------------------------------------
   // Clock, reset, channels, CSR port
   // ---------------------------------------------------------------------------
   logic clock = 1'b0;
   logic reset = 1'b1;

   always #10 clock = ~clock;

   bcc_req_if req_chan ();
   bcc_rsp_if rsp_chan ();

   logic                     csr_write_enable = 1'b0;
   logic [CsrIndexWidth-1:0] csr_index        = '0;
   logic [CfgWidth-1:0]      csr_write_data   = '0;

   button_click_classifier DUT (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // ---------------------------------------------------------------------------
   // Gesture model: own copy of thresholds and timestamps
   // ---------------------------------------------------------------------------
   cfg_type        thr;
   phase_type      phase_now;
   logic [31:0]    press_at;       // first press
   logic [31:0]    release_at;     // first release
   logic [31:0]    second_at;      // second press

   rsp_item_type   expected_gestures[$];
   int             mismatches = 0;

   // Side info for the item currently on the bus: a typed-in result wins over
   // the model for directed rows.
   bit             row_typed = 1'b0;
   rsp_item_type   row_result;

   int             send_idle_pct = 0;
   int             recv_idle_pct = 0;
   int             hold_requests = 0;
   int             holds_done    = 0;

   logic [31:0]    now_tick;
   int             stim_count = 0;

   function automatic rsp_item_type classify(input req_item_type it);
      rsp_item_type r;
      logic [31:0]  since_release;
      logic [31:0]  held;
      r.gesture    = G_NONE;
      r.span_ticks = '0;
      // window runs out on any transfer, edge or check, confirmed or not
      since_release = it.time_stamp - release_at;
      if (phase_now == PH_WAIT && since_release >= 32'(thr.double_window_ticks)) begin
         r.gesture    = G_SINGLE;
         r.span_ticks = release_at - press_at;
         phase_now    = PH_IDLE;
      end
      if (it.command == CMD_EDGE && it.confirmed) begin
         case (phase_now)
            PH_IDLE: begin
               if (it.level == LVL_PRESSED) begin
                  press_at  = it.time_stamp;
                  phase_now = PH_FIRST;
               end
            end
            PH_FIRST: begin
               if (it.level == LVL_RELEASED) begin
                  held = it.time_stamp - press_at;
                  if (held < 32'(thr.min_press_ticks)) begin
                     phase_now = PH_IDLE;                // glitch, dropped
                  end else if (held >= 32'(thr.long_press_ticks)) begin
                     r.gesture    = G_LONG;
                     r.span_ticks = held;
                     phase_now    = PH_IDLE;
                  end else begin
                     release_at = it.time_stamp;
                     phase_now  = PH_WAIT;
                  end
               end
            end
            PH_WAIT: begin
               if (it.level == LVL_PRESSED) begin
                  second_at = it.time_stamp;
                  phase_now = PH_SECOND;
               end
            end
            default: begin
               if (it.level == LVL_RELEASED) begin
                  held = it.time_stamp - second_at;
                  if (held < 32'(thr.min_press_ticks)) begin
                     r.gesture    = G_SINGLE;            // glitchy second press
                     r.span_ticks = release_at - press_at;
                  end else if (held >= 32'(thr.long_press_ticks)) begin
                     r.gesture    = G_LONG;
                     r.span_ticks = held;
                  end else begin
                     r.gesture    = G_DOUBLE;
                     r.span_ticks = second_at - release_at;
                  end
                  phase_now = PH_IDLE;
               end
            end
         endcase
      end
      return r;
   endfunction

   // ---------------------------------------------------------------------------
   // Bus watcher: score results first, then record newly accepted events
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin : watch
      rsp_item_type want;
      rsp_item_type predicted;
      req_item_type seen;
      if (!reset) begin
         if (rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
            if (expected_gestures.size() == 0) begin
               $error("unexpected result: gesture %0d span_ticks %0d",
                      rsp_chan.gesture, rsp_chan.span_ticks);
               mismatches++;
            end else begin
               want = expected_gestures.pop_front();
               if (rsp_chan.gesture !== want.gesture) begin
                  $error("gesture: expected %0d, actual %0d", want.gesture, rsp_chan.gesture);
                  mismatches++;
               end
               if (rsp_chan.span_ticks !== want.span_ticks) begin
                  $error("span_ticks: expected %0d, actual %0d",
                         want.span_ticks, rsp_chan.span_ticks);
                  mismatches++;
               end
            end
         end
         if (req_chan.valid === 1'b1 && req_chan.ready === 1'b1) begin
            seen.command    = req_chan.command;
            seen.level      = req_chan.level;
            seen.confirmed  = req_chan.confirmed;
            seen.time_stamp = req_chan.time_stamp;
            predicted = classify(seen);    // always run so model state tracks
            if (row_typed) expected_gestures.push_back(row_result);
            else           expected_gestures.push_back(predicted);
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Result sink: random back-pressure, plus long hold-offs on request
   // ---------------------------------------------------------------------------
   initial begin : receiver
      int held_left;
      held_left = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_requests != holds_done) begin
            holds_done = holds_done + 1;
            held_left  = LONG_HOLD;
         end
         if (held_left > 0) begin
            held_left--;
            rsp_chan.ready = 1'b0;
         end else begin
            rsp_chan.ready = ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Driver helpers (all run on the falling edge)
   // ---------------------------------------------------------------------------
   task automatic send_item(input req_item_type item, input bit typed,
                            input gesture_type g, input logic [31:0] span);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_chan.valid = 1'b0;
         @(negedge clock);
      end
      req_chan.valid      = 1'b1;
      req_chan.command    = item.command;
      req_chan.level      = item.level;
      req_chan.confirmed  = item.confirmed;
      req_chan.time_stamp = item.time_stamp;
      row_typed             = typed;
      row_result.gesture    = g;
      row_result.span_ticks = span;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      @(negedge clock);
   endtask

   // One gesture event, sometimes preceded by a stray one.
   task automatic send_event(input logic cmd, input logic lvl, input logic conf,
                             input logic [31:0] t);
      req_item_type it;
      if ($urandom_range(0, 9) == 0) begin
         it.command    = 1'($urandom_range(0, 1));
         it.level      = 1'($urandom_range(0, 1));
         // mostly unconfirmed edges or checks; now and then a real stray edge
         it.confirmed  = it.command ? 1'($urandom_range(0, 1))
                                    : ($urandom_range(0, 3) == 0);
         it.time_stamp = ($urandom_range(0, 7) == 0) ? $urandom() : t;
         send_item(it, 1'b0, G_NONE, '0);
      end
      it.command    = cmd;
      it.level      = lvl;
      it.confirmed  = conf;
      it.time_stamp = t;
      send_item(it, 1'b0, G_NONE, '0);
      stim_count++;
   endtask

   // Wait until every result is back, then let the pipe settle.
   task automatic wait_idle();
      req_chan.valid = 1'b0;
      while (expected_gestures.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic set_register(input csr_index_type idx, input logic [CfgWidth-1:0] value);
      csr_write_enable = 1'b1;
      csr_index        = idx;
      csr_write_data   = value;
      case (idx)
         CSR_MIN_PRESS:  thr.min_press_ticks  = value;
         CSR_LONG_PRESS: thr.long_press_ticks = value;
         default:        thr.double_window_ticks = value;
      endcase
      @(negedge clock);
   endtask

   task automatic load_thresholds(input logic [CfgWidth-1:0] min_t,
                                  input logic [CfgWidth-1:0] long_t,
                                  input logic [CfgWidth-1:0] win_t);
      wait_idle();
      set_register(CSR_MIN_PRESS, min_t);
      set_register(CSR_LONG_PRESS, long_t);
      set_register(CSR_DOUBLE_WINDOW, win_t);
      csr_write_enable = 1'b0;
   endtask

   // ---------------------------------------------------------------------------
   // Span pickers, biased toward the threshold edges
   // ---------------------------------------------------------------------------
   function automatic int unsigned pick(input int unsigned lo, input int unsigned hi);
      return (lo <= hi) ? $urandom_range(hi, lo) : lo;
   endfunction

   function automatic int unsigned short_span();
      int unsigned lo;
      int unsigned hi;
      lo = 32'(thr.min_press_ticks);
      hi = (thr.long_press_ticks > 0) ? 32'(thr.long_press_ticks) - 1 : 0;
      case ($urandom_range(0, 3))
         0:       return lo;
         1:       return (hi >= lo) ? hi : lo;
         default: return pick(lo, hi);
      endcase
   endfunction

   function automatic int unsigned glitch_span();
      if (thr.min_press_ticks == 0) return 0;
      return $urandom_range(0, 1) ? thr.min_press_ticks - 1 : pick(0, thr.min_press_ticks - 1);
   endfunction

   function automatic int unsigned long_span();
      int unsigned lo;
      lo = (thr.long_press_ticks > thr.min_press_ticks) ? 32'(thr.long_press_ticks)
                                                        : 32'(thr.min_press_ticks);
      return $urandom_range(0, 1) ? lo : lo + $urandom_range(0, 3000);
   endfunction

   function automatic int unsigned inside_window();
      if (thr.double_window_ticks == 0) return 0;
      return $urandom_range(0, 1) ? thr.double_window_ticks - 1
                                  : pick(0, thr.double_window_ticks - 1);
   endfunction

   function automatic int unsigned past_window();
      return thr.double_window_ticks + ($urandom_range(0, 1) ? 0 : $urandom_range(0, 400));
   endfunction

   // ---------------------------------------------------------------------------
   // One random, mostly well-formed gesture
   // ---------------------------------------------------------------------------
   task automatic play_gesture();
      int kind;
      kind = $urandom_range(0, 5);
      send_event(CMD_EDGE, LVL_PRESSED, 1'b1, now_tick);
      case (kind)
         2:       now_tick += long_span();
         3:       now_tick += glitch_span();
         default: now_tick += short_span();
      endcase
      send_event(CMD_EDGE, LVL_RELEASED, 1'b1, now_tick);
      if (kind == 0) begin
         // single click: let the window run out, by a check or the next press
         now_tick += past_window();
         if ($urandom_range(0, 1)) send_event(CMD_CHECK, 1'($urandom_range(0, 1)),
                                              1'($urandom_range(0, 1)), now_tick);
      end else if (kind == 1 || kind >= 4) begin
         now_tick += inside_window();
         send_event(CMD_EDGE, LVL_PRESSED, 1'b1, now_tick);
         case (kind)
            4:       now_tick += glitch_span();
            5:       now_tick += long_span();
            default: now_tick += short_span();
         endcase
         send_event(CMD_EDGE, LVL_RELEASED, 1'b1, now_tick);
      end
      now_tick += $urandom_range(0, 50);
   endtask

   task automatic run_random(input int quota);
      int target;
      target = stim_count + quota;
      if ($urandom_range(0, 3) == 0) now_tick = 32'hFFFF_F000 + $urandom_range(0, 4000);
      else                           now_tick = $urandom();
      while (stim_count < target) play_gesture();
   endtask

   // ---------------------------------------------------------------------------
   // Directed events under the reset thresholds 30 / 1500 / 300
   // ---------------------------------------------------------------------------
   typedef struct {
      logic        command;
      logic        level;
      logic        confirmed;
      logic [31:0] time_stamp;
      bit          typed;
      gesture_type gesture;
      logic [31:0] span;
   } directed_row_type;

   directed_row_type dir_rows [25] = '{
      // nothing to do right after reset
      '{CMD_CHECK, LVL_PRESSED,  1'b1, 32'd0,    1'b1, G_NONE,   32'd0},
      // release while idle is ignored
      '{CMD_EDGE,  LVL_RELEASED, 1'b1, 32'd5,    1'b1, G_NONE,   32'd0},
      '{CMD_EDGE,  LVL_PRESSED,  1'b1, 32'd100,  1'b0, G_NONE,   32'd0},
      // press while pressed, unconfirmed release: both ignored
      '{CMD_EDGE,  LVL_PRESSED,  1'b1, 32'd110,  1'b0, G_NONE,   32'd0},
      '{CMD_EDGE,  LVL_RELEASED, 1'b0, 32'd120,  1'b0, G_NONE,   32'd0},
      // 10-tick first press is a glitch
      '{CMD_EDGE,  LVL_RELEASED, 1'b1, 32'd110,  1'b0, G_NONE,   32'd0},
      // long press exactly at threshold
      '{CMD_EDGE,  LVL_PRESSED,  1'b1, 32'd1000, 1'b0, G_NONE,   32'd0},
      '{CMD_EDGE,  LVL_RELEASED, 1'b1, 32'd2500, 1'b1, G_LONG,   32'd1500},
      // press of exactly min, then a stray release while waiting
      '{CMD_EDGE,  LVL_PRESSED,  1'b1, 32'd4000, 1'b0, G_NONE,   32'd0},
      '{CMD_EDGE,  LVL_RELEASED, 1'b1, 32'd4030, 1'b0, G_NONE,   32'd0},
      '{CMD_EDGE,  LVL_RELEASED, 1'b1, 32'd4100, 1'b0, G_NONE,   32'd0},
      // second press one tick inside the window: double click
      '{CMD_EDGE,  LVL_PRESSED,  1'b1, 32'd4329, 1'b0, G_NONE,   32'd0},
      '{CMD_EDGE,  LVL_RELEASED, 1'b1, 32'd4400, 1'b1, G_DOUBLE, 32'd299},
      // glitchy second press falls back to single click
      '{CMD_EDGE,  LVL_PRESSED,  1'b1, 32'd6000, 1'b0, G_NONE,   32'd0},
      '{CMD_EDGE,  LVL_RELEASED, 1'b1, 32'd6200, 1'b0, G_NONE,   32'd0},
      '{CMD_EDGE,  LVL_PRESSED,  1'b1, 32'd6250, 1'b0, G_NONE,   32'd0},
      '{CMD_EDGE,  LVL_RELEASED, 1'b1, 32'd6260, 1'b1, G_SINGLE, 32'd200},
      // long second press
      '{CMD_EDGE,  LVL_PRESSED,  1'b1, 32'd7000, 1'b0, G_NONE,   32'd0},
      '{CMD_EDGE,  LVL_RELEASED, 1'b1, 32'd7040, 1'b0, G_NONE,   32'd0},
      '{CMD_EDGE,  LVL_PRESSED,  1'b1, 32'd7100, 1'b0, G_NONE,   32'd0},
      '{CMD_EDGE,  LVL_RELEASED, 1'b1, 32'd8600, 1'b1, G_LONG,   32'd1500},
      // press across the 32-bit wrap
      '{CMD_EDGE,  LVL_PRESSED,  1'b1, 32'hFFFF_FFF0, 1'b0, G_NONE, 32'd0},
      '{CMD_EDGE,  LVL_RELEASED, 1'b1, 32'h0000_0010, 1'b0, G_NONE, 32'd0},
      // window runs out on a press: single click, and the press starts anew
      '{CMD_EDGE,  LVL_PRESSED,  1'b1, 32'd316,  1'b1, G_SINGLE, 32'd32},
      // all-ones check while pressed
      '{CMD_CHECK, LVL_RELEASED, 1'b1, 32'hFFFF_FFFF, 1'b1, G_NONE, 32'd0}
   };

   // ---------------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------------
   initial begin : stimulus
      req_item_type it;
      int           min_r;
      int           long_r;

      req_chan.valid      = 1'b0;
      req_chan.command    = CMD_EDGE;
      req_chan.level      = LVL_RELEASED;
      req_chan.confirmed  = 1'b0;
      req_chan.time_stamp = '0;
      row_result.gesture    = G_NONE;
      row_result.span_ticks = '0;

      thr.min_press_ticks     = MinPressReset;
      thr.long_press_ticks    = LongPressReset;
      thr.double_window_ticks = DoubleWindowReset;
      phase_now  = PH_IDLE;
      press_at   = '0;
      release_at = '0;
      second_at  = '0;

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // sender mostly busy, receiver mostly stalled
      send_idle_pct = 27;
      recv_idle_pct = 68;

      foreach (dir_rows[i]) begin
         it.command    = dir_rows[i].command;
         it.level      = dir_rows[i].level;
         it.confirmed  = dir_rows[i].confirmed;
         it.time_stamp = dir_rows[i].time_stamp;
         send_item(it, dir_rows[i].typed, dir_rows[i].gesture, dir_rows[i].span);
      end
      wait_idle();
      row_typed = 1'b0;

      // reset thresholds still in place
      run_random(60);

      // one-tick glitch limit, widest long limit and window
      load_thresholds(16'd1, 16'hFFFF, 16'hFFFF);
      run_random(50);

      // flip the idling
      send_idle_pct = 68;
      recv_idle_pct = 27;

      // the other extreme: almost every press is a glitch, window of one tick
      load_thresholds(16'hFFFF, 16'd1, 16'd1);
      run_random(40);

      // all zero: no glitches, every press long, window closes at once
      load_thresholds(16'd0, 16'd0, 16'd0);
      run_random(40);

      min_r  = $urandom_range(1, 60);
      long_r = $urandom_range(min_r + 1, 600);
      load_thresholds(16'(min_r), 16'(long_r), 16'($urandom_range(1, 300)));
      run_random(60);

      // no idling from here on
      send_idle_pct = 0;
      recv_idle_pct = 0;

      min_r  = $urandom_range(1, 60);
      long_r = $urandom_range(min_r + 1, 600);
      load_thresholds(16'(min_r), 16'(long_r), 16'($urandom_range(1, 300)));

      // long receiver hold-off while the sender keeps pushing: input stalls
      hold_requests++;
      @(negedge clock);
      run_random(15);
      // sender pauses until the backlog is gone
      wait_idle();
      run_random(55);

      min_r  = $urandom_range(1, 200);
      long_r = $urandom_range(min_r + 1, 2000);
      load_thresholds(16'(min_r), 16'(long_r), 16'($urandom_range(1, 1000)));
      run_random(60);

      wait_idle();
      repeat (10) @(negedge clock);

      if (mismatches == 0 && expected_gestures.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   // Run limit, far above the slowest legal run.
   initial begin : watchdog
      #5_000_000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule
